@@ rtl/core/rgbhsb_pkg.sv @@
// Package: widths and types shared by the RGB to HSB converter.
package rgbhsb_pkg;
  localparam int COMPONENT_BITS = 8;
  localparam int FRACTION_BITS = 16;
  localparam int HUE_BITS = FRACTION_BITS;
  localparam int SAT_BITS = FRACTION_BITS + 1;
  // divisor is at most 6*d, so three extra bits over the component
  localparam int DIV_BITS = COMPONENT_BITS + 3;
  // partial remainder needs one bit above the divisor
  localparam int REM_BITS = DIV_BITS + 1;
  // one quotient bit per cell, two divides in parallel
  localparam int NUM_CELLS = SAT_BITS;

  typedef struct packed {
    logic [REM_BITS-1:0] hue_rem;
    logic [DIV_BITS-1:0] hue_div;
    logic [HUE_BITS-1:0] hue_q;
    logic [REM_BITS-1:0] sat_rem;
    logic [DIV_BITS-1:0] sat_div;
    logic [SAT_BITS-1:0] sat_q;
    logic [COMPONENT_BITS-1:0] brightness;
  } cell_data_t;
endpackage

@@ rtl/core/rgbhsb_if.sv @@
// Interfaces: pixel request and HSB result channels.
interface rgbhsb_pixel_if import rgbhsb_pkg::*; ();
  logic valid;
  logic ready;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbhsb_hsb_if import rgbhsb_pkg::*; ();
  logic valid;
  logic ready;
  logic [HUE_BITS-1:0] hue;
  logic [SAT_BITS-1:0] saturation;
  logic [COMPONENT_BITS-1:0] brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

@@ rtl/core/rgbhsb_front.sv @@
// Front stage: max, min, sector numerator and divisors for one pixel.
module rgbhsb_front import rgbhsb_pkg::*; (
  input  logic clk,
  input  logic advance,
  input  logic [COMPONENT_BITS-1:0] red,
  input  logic [COMPONENT_BITS-1:0] green,
  input  logic [COMPONENT_BITS-1:0] blue,
  output cell_data_t data
);
  logic [COMPONENT_BITS-1:0] cmax, cmin, d;
  logic signed [DIV_BITS:0] num, num_adj;
  logic [DIV_BITS-1:0] six_d;
  cell_data_t data_next;

  always_comb begin
    cmax = (red > green) ? red : green;
    cmin = (red < green) ? red : green;
    if (blue > cmax) cmax = blue;
    if (blue < cmin) cmin = blue;
    d = cmax - cmin;
    six_d = DIV_BITS'(d) * DIV_BITS'(6);
    priority if (red == cmax) begin
      num = $signed({3'b0, green}) - $signed({3'b0, blue});
    end else if (green == cmax) begin
      num = $signed({2'b0, d, 1'b0}) + $signed({3'b0, blue}) - $signed({3'b0, red});
    end else begin
      num = $signed({1'b0, d, 2'b0}) + $signed({3'b0, red}) - $signed({3'b0, green});
    end
    num_adj = (num < 0) ? num + $signed({1'b0, six_d}) : num;
    data_next = '0;
    data_next.brightness = cmax;
    // zero divisor marks a zero result; the cells skip it
    data_next.hue_div = six_d;
    data_next.hue_rem = (d == '0) ? '0 : REM_BITS'(unsigned'(num_adj));
    data_next.sat_div = DIV_BITS'(cmax);
    data_next.sat_rem = (cmax == '0) ? '0 : REM_BITS'(d);
  end

  always_ff @(posedge clk) begin
    if (advance) data <= data_next;
  end
endmodule

@@ rtl/core/rgbhsb_cell.sv @@
// Divide cell: one restoring step of the saturation quotient and, when hue_on, of the hue quotient.
module rgbhsb_cell import rgbhsb_pkg::*; (
  input  logic clk,
  input  logic advance,
  input  logic hue_on,
  input  cell_data_t din,
  output cell_data_t dout
);
  cell_data_t nxt;
  logic [REM_BITS-1:0] hs, ss;

  always_comb begin
    nxt = din;
    hs = {din.hue_rem[REM_BITS-2:0], 1'b0};
    // first cell takes the integer bit from the unshifted remainder
    ss = hue_on ? {din.sat_rem[REM_BITS-2:0], 1'b0} : din.sat_rem;
    if (hue_on) begin
      nxt.hue_q = {din.hue_q[HUE_BITS-2:0], 1'b0};
      if (din.hue_div != '0 && hs >= REM_BITS'(din.hue_div)) begin
        nxt.hue_rem = hs - REM_BITS'(din.hue_div);
        nxt.hue_q[0] = 1'b1;
      end else begin
        nxt.hue_rem = hs;
      end
    end
    nxt.sat_q = {din.sat_q[SAT_BITS-2:0], 1'b0};
    if (din.sat_div != '0 && ss >= REM_BITS'(din.sat_div)) begin
      nxt.sat_rem = ss - REM_BITS'(din.sat_div);
      nxt.sat_q[0] = 1'b1;
    end else begin
      nxt.sat_rem = ss;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) dout <= nxt;
  end
endmodule

@@ rtl/core/rgb_to_hsb_converter.sv @@
// Top level: RGB to HSB pixel converter, front stage plus a chain of divide cells.
//  channel | dir | payload
//  pix     | in  | red, green, blue (8 b each)
//  hsb     | out | hue 0.16, saturation 1.16, brightness 8 b
// One pixel per cycle unless the output stalls; a pixel passes the front stage
// and NUM_CELLS divide cells, one quotient bit per divide cell. Saturation's
// first cell yields its integer bit, so the hue divide starts one cell later.
// Reset clears the valid bits only. A stall at the output freezes the whole
// chain; the input is ready whenever the last stage is empty or being taken.
module rgb_to_hsb_converter import rgbhsb_pkg::*; (
  input logic clk,
  input logic rst,
  rgbhsb_pixel_if.sink pix,
  rgbhsb_hsb_if.source hsb
);
  localparam int STAGES = NUM_CELLS + 1;
  logic [STAGES-1:0] vld;
  logic advance;
  cell_data_t chain [STAGES];

  assign advance = !vld[STAGES-1] || hsb.ready;
  assign pix.ready = advance;

  rgbhsb_front u_front (
    .clk(clk), .advance(advance), .red(pix.red), .green(pix.green),
    .blue(pix.blue), .data(chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rgbhsb_cell u_cell (
      .clk(clk), .advance(advance), .hue_on(i != 0),
      .din(chain[i]), .dout(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[STAGES-2:0], pix.valid};
    end
  end

  assign hsb.valid = vld[STAGES-1];
  assign hsb.hue = chain[STAGES-1].hue_q;
  assign hsb.saturation = chain[STAGES-1].sat_q;
  assign hsb.brightness = chain[STAGES-1].brightness;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld)) else $error("valid chain moved during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !hsb.valid |-> pix.ready) else $error("input blocked with empty output");
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    hsb.valid |-> (!hsb.saturation[SAT_BITS-1] || hsb.saturation[SAT_BITS-2:0] == '0))
    else $error("saturation above one");
  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsb.valid && hsb.brightness == '0) |-> (hsb.hue == '0 && hsb.saturation == '0))
    else $error("black pixel with nonzero hue or saturation");
endmodule

@@ test/tb_rgb_to_hsb_converter.sv @@
// Testbench for the RGB to HSB converter: directed and random pixels checked against a predictor.
module tb_rgb_to_hsb_converter;
  import rgbhsb_pkg::*;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    logic [COMPONENT_BITS-1:0] brightness;
  } hsb_t;

  localparam int LATENCY = 1 + NUM_CELLS;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  rgbhsb_pixel_if pix ();
  rgbhsb_hsb_if hsb ();

  rgb_to_hsb_converter DUT (.clk(clk), .rst(rst), .pix(pix), .hsb(hsb));

  hsb_t expected_hsb[$];
  int failures = 0;
  int cycles = 0;
  bit no_idle = 0;
  int hold_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic hsb_t predict_hsb(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    longint r, g, b, cmax, cmin, d, num;
    hsb_t res;
    r = longint'(r8);
    g = longint'(g8);
    b = longint'(b8);
    cmax = (r > g) ? r : g;
    cmin = (r < g) ? r : g;
    if (b > cmax) cmax = b;
    if (b < cmin) cmin = b;
    d = cmax - cmin;
    res = '0;
    res.brightness = cmax[7:0];
    if (cmax != 0) res.saturation = SAT_BITS'((d << FRACTION_BITS) / cmax);
    if (d != 0) begin
      if (r == cmax) num = g - b;
      else if (g == cmax) num = 2 * d + (b - r);
      else num = 4 * d + (r - g);
      if (num < 0) num += 6 * d;
      res.hue = HUE_BITS'((num << FRACTION_BITS) / (6 * d));
    end
    return res;
  endfunction

  // receiver: random stall unless a hold is counting down or idling is off
  always @(posedge clk) begin
    if (rst) begin
      hsb.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      hsb.ready <= 1'b0;
    end else begin
      hsb.ready <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    hsb_t got, want;
    if (!rst && hsb.valid && hsb.ready) begin
      got = '{hsb.hue, hsb.saturation, hsb.brightness};
      if (expected_hsb.size() == 0) begin
        $error("result with no pixel pending");
        failures++;
      end else begin
        want = expected_hsb.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue expected %0d actual %0d", want.hue, got.hue);
          failures++;
        end
        if (got.saturation !== want.saturation) begin
          $error("saturation expected %0d actual %0d", want.saturation, got.saturation);
          failures++;
        end
        if (got.brightness !== want.brightness) begin
          $error("brightness expected %0d actual %0d", want.brightness, got.brightness);
          failures++;
        end
      end
    end
  end

  // hold the request until taken; drain, or an idle gap in the next call, drops valid
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 33) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red <= r;
    pix.green <= g;
    pix.blue <= b;
    expected_hsb.push_back(predict_hsb(r, g, b));
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  task automatic drain;
    pix.valid <= 1'b0;
    while (expected_hsb.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_directed;
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 0, 1);
    send_pixel(200, 10, 90);
    send_pixel(255, 254, 255);
    send_pixel(255, 255, 254);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 1);
    send_pixel(10, 20, 30);
    send_pixel(30, 20, 10);
    send_pixel(20, 30, 10);
    send_pixel(170, 85, 51);
  endtask

  task automatic test_random(int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      // bias some pixels toward near-grey and ties
      case ($urandom_range(3))
        0: g = 8'(r + $urandom_range(2) - 1);
        1: b = $urandom_range(1) ? r : g;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_backpressure;
    // hold the output off while pixels keep coming, filling the pipeline
    hold_cycles = 60;
    test_random(40);
    drain();
  endtask

  task automatic test_full_rate;
    no_idle = 1;
    test_random(150);
    no_idle = 0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_random(300);
    test_backpressure();
    test_full_rate();
    test_random(340);
    drain();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
